// ----- rtl/brp_pkg.sv -----
// brp_pkg: shared types and constants for the byte ring pipe
// used by every rtl file of the block except brp_ram; depends on nothing

package brp_pkg;

  // storage defaults
  localparam int DEPTH_DEF = 256;

  // field widths
  localparam int BYTE_W = 8;
  localparam int SIZE_W = 9;
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W = 1;

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;
  localparam logic              WAKE_EN_RST = 1'b1;

  // minimum ring length
  localparam int SIZE_MIN = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIPE_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_ENABLE = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new request
    logic exec;   // carry out the captured request
    logic show;   // result is on the output ports
  } cmd_t;

endpackage

// ----- rtl/byte_ring_pipe.sv -----
// byte_ring_pipe: top level of the byte ring buffer pipe
// depends on brp_pkg, brp_ctrl, brp_datapath (and brp_ram below it)
//
//  channel   ports                              handshake
//  --------  ---------------------------------  -----------------------------
//  request   in_operation, in_write_byte        start high while busy low
//  result    out_read_byte, out_done_res,       out_strobe, one cycle, no stall
//            out_available, out_space, out_wake
//  config    cfg_index, cfg_wdata               cfg_we, taken at once
//
//  each request passes through the execute cycle, which updates the positions
//  and accesses the byte RAM, then the result cycle, in which the registered
//  RAM read data is shown; a new request is taken during the result cycle
//  busy is high only in the execute cycle
//  synchronous active-low reset empties the pipe; the RAM needs no clearing pass
//  the receiver cannot stall; each result is shown for exactly one cycle

module byte_ring_pipe #(
  parameter int DEPTH = brp_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [brp_pkg::OP_W-1:0]      in_operation,
  input  logic [brp_pkg::BYTE_W-1:0]    in_write_byte,
  output logic                          out_strobe,
  output logic [brp_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                          out_done_res,
  output logic [brp_pkg::BYTE_W-1:0]    out_available,
  output logic [brp_pkg::BYTE_W-1:0]    out_space,
  output logic                          out_wake,
  input  logic                          cfg_we,
  input  logic [brp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brp_pkg::SIZE_W-1:0]    cfg_wdata
);

  brp_pkg::cmd_t cmd;

  // sequencer
  brp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // ring datapath
  brp_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_write_byte (in_write_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_read_byte (out_read_byte),
    .out_done_res  (out_done_res),
    .out_available (out_available),
    .out_space     (out_space),
    .out_wake      (out_wake)
  );

endmodule

// ----- rtl/brp_ram.sv -----
// brp_ram: generic single-write, single-read RAM with registered read data
// standalone; no package needed

module brp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/brp_ctrl.sv -----
// brp_ctrl: request sequencer for the byte ring pipe
// depends on brp_pkg (state_t, cmd_t)

module brp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output brp_pkg::cmd_t cmd
);

  brp_pkg::state_t state_r, state_nxt;
  logic            accept;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    busy     = (state_r == brp_pkg::ST_EXEC);
    accept   = start && !busy;
    cmd.load = accept;
    cmd.exec = (state_r == brp_pkg::ST_EXEC);
    cmd.show = (state_r == brp_pkg::ST_RESULT);
    unique case (state_r)
      brp_pkg::ST_IDLE: begin
        state_nxt = accept ? brp_pkg::ST_EXEC : brp_pkg::ST_IDLE;
      end
      brp_pkg::ST_EXEC: begin
        state_nxt = brp_pkg::ST_RESULT;
      end
      brp_pkg::ST_RESULT: begin
        state_nxt = accept ? brp_pkg::ST_EXEC : brp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = brp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/brp_datapath.sv -----
// brp_datapath: ring positions, config registers, fill math and byte store
// depends on brp_pkg and brp_ram

module brp_datapath #(
  parameter int DEPTH = brp_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  brp_pkg::cmd_t                     cmd,
  input  logic [brp_pkg::OP_W-1:0]          in_operation,
  input  logic [brp_pkg::BYTE_W-1:0]        in_write_byte,
  input  logic                              cfg_we,
  input  logic [brp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brp_pkg::SIZE_W-1:0]        cfg_wdata,
  output logic                              out_strobe,
  output logic [brp_pkg::BYTE_W-1:0]        out_read_byte,
  output logic                              out_done_res,
  output logic [brp_pkg::BYTE_W-1:0]        out_available,
  output logic [brp_pkg::BYTE_W-1:0]        out_space,
  output logic                              out_wake
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam int CW = (NW > brp_pkg::SIZE_W) ? NW : brp_pkg::SIZE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] MIN_C   = CW'(brp_pkg::SIZE_MIN);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // request and state registers
  logic [brp_pkg::OP_W-1:0]   op_r;
  logic [brp_pkg::BYTE_W-1:0] byte_r;
  logic [PW-1:0]              wr_pos_r, wr_pos_nxt;
  logic [PW-1:0]              rd_pos_r, rd_pos_nxt;
  logic [brp_pkg::SIZE_W-1:0] size_r;
  logic                       wake_en_r;
  logic                       done_r, done_nxt;
  logic                       wake_r, wake_nxt;
  logic                       rd_ok_r, rd_ok_nxt;

  // fill math
  logic [CW-1:0] size_x, ring_n, wp_x, rp_x, avail, wp_inc, rp_inc, space_x;
  logic          can_rd, can_wr, ram_we, ram_re;
  logic [brp_pkg::BYTE_W-1:0] ram_rdata;

  // ring length clamp
  always_comb begin
    size_x = CW'(size_r);
    priority if (size_x < MIN_C) begin
      ring_n = MIN_C;
    end else if (size_x > DEPTH_C) begin
      ring_n = DEPTH_C;
    end else begin
      ring_n = size_x;
    end
  end

  // bytes stored, free slots and next positions
  always_comb begin
    wp_x    = CW'(wr_pos_r);
    rp_x    = CW'(rd_pos_r);
    avail   = (wp_x >= rp_x) ? (wp_x - rp_x) : (ring_n + wp_x - rp_x);
    space_x = ring_n - avail - ONE_C;
    can_rd  = (avail != '0);
    can_wr  = (space_x != '0);
    wp_inc  = (wp_x + ONE_C == ring_n) ? '0 : (wp_x + ONE_C);
    rp_inc  = (rp_x + ONE_C == ring_n) ? '0 : (rp_x + ONE_C);
  end

  // execution of the captured request
  always_comb begin
    wr_pos_nxt = wr_pos_r;
    rd_pos_nxt = rd_pos_r;
    done_nxt   = 1'b0;
    wake_nxt   = 1'b0;
    rd_ok_nxt  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    unique case (op_r)
      brp_pkg::OP_READ: begin
        if (can_rd) begin
          ram_re     = cmd.exec;
          rd_pos_nxt = PW'(rp_inc);
          done_nxt   = 1'b1;
          rd_ok_nxt  = 1'b1;
        end
      end
      brp_pkg::OP_WRITE: begin
        if (can_wr) begin
          ram_we     = cmd.exec;
          wr_pos_nxt = PW'(wp_inc);
          done_nxt   = 1'b1;
          wake_nxt   = !can_rd && wake_en_r;
        end
      end
      brp_pkg::OP_CLEAR: begin
        wr_pos_nxt = '0;
        rd_pos_nxt = '0;
        done_nxt   = 1'b1;
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      byte_r <= in_write_byte;
    end
  end

  // positions, config registers and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r  <= '0;
      rd_pos_r  <= '0;
      size_r    <= brp_pkg::SIZE_RST;
      wake_en_r <= brp_pkg::WAKE_EN_RST;
      done_r    <= 1'b0;
      wake_r    <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        wr_pos_r <= wr_pos_nxt;
        rd_pos_r <= rd_pos_nxt;
        done_r   <= done_nxt;
        wake_r   <= wake_nxt;
        rd_ok_r  <= rd_ok_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          brp_pkg::CFG_PIPE_SIZE: begin
            size_r   <= cfg_wdata;
            wr_pos_r <= '0;
            rd_pos_r <= '0;
          end
          brp_pkg::CFG_WAKE_ENABLE: begin
            wake_en_r <= cfg_wdata[0];
          end
          default: begin
            wake_en_r <= wake_en_r;
          end
        endcase
      end
    end
  end

  // byte store
  brp_ram #(
    .WIDTH (brp_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (rd_pos_r),
    .rdata (ram_rdata)
  );

  // result ports, live in the result cycle
  assign out_strobe    = cmd.show;
  assign out_read_byte = rd_ok_r ? ram_rdata : '0;
  assign out_done_res  = done_r;
  assign out_wake      = wake_r;
  assign out_available = avail[brp_pkg::BYTE_W-1:0];
  assign out_space     = space_x[brp_pkg::BYTE_W-1:0];

endmodule

// ----- rtl/brp_checker.sv -----
// brp_checker: port-level assertions for byte_ring_pipe, bound to the top level
// depends on brp_pkg and byte_ring_pipe

module brp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [brp_pkg::BYTE_W-1:0]    out_read_byte,
  input logic                          out_done_res,
  input logic [brp_pkg::BYTE_W-1:0]    out_available,
  input logic                          out_wake
);

  // every accepted request goes busy, then shows its result with busy low
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy ##1 (out_strobe && !busy)))
    else $error("accepted request did not execute and report");

  // a result strobe only follows an execute cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  // a refused result, or any result with done low, carries no byte and no wake
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_done_res) |-> (out_read_byte == '0 && !out_wake))
    else $error("refused request reported data or wake");

  // wake means the pipe now holds exactly the one byte just written
  a_wake_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_wake) |-> (out_done_res && out_available == 8'd1))
    else $error("wake reported without a single stored byte");

endmodule

bind byte_ring_pipe brp_checker u_brp_checker (.*);
